// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsd_pkg
// constants and types of the bmp pixel stream decoder
// ----------------------------------------------------------------------------
package bpsd_pkg;

	// defaults of the top level parameters
	localparam int DEF_MAX_WIDTH     = 640;
	localparam int DEF_MAX_HEIGHT    = 480;
	localparam int DEF_PALETTE_DEPTH = 256;

	// header layout, byte position of the last byte of each field; HDR_DATA_END is where the data end is computed
	localparam int HEADER_BYTES       = 54;
	localparam int HDR_DATA_OFFSET    = 13;
	localparam int HDR_WIDTH          = 21;
	localparam int HDR_HEIGHT         = 25;
	localparam int HDR_IMAGE_BYTES    = 37;
	localparam int HDR_DATA_END       = 38;
	localparam int HDR_COLOR_COUNT    = 49;

	// palette region offset counter, saturates past the largest table
	localparam int PAL_BYTE_W = 11;

	// output field widths
	localparam int PIXEL_X_W   = 10;
	localparam int PIXEL_Y_W   = 10;
	localparam int COLOR_W     = 32;
	localparam int OUT_TDATA_W = 56;

	// byte of a B,G,R group expected next
	typedef enum logic [1:0] {
		PH_BLUE,
		PH_GREEN,
		PH_RED
	} color_phase_t;

	typedef struct packed {
		logic [PIXEL_X_W-1:0] x;
		logic [PIXEL_Y_W-1:0] y;
		logic [COLOR_W-1:0]   color;
		logic                 last;
	} pixel_t;

endpackage

// ===== rtl/bmp_pixel_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_top
// parses a bmp file byte stream, loads the palette and emits positioned pixels
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: file_byte, tuser: first_byte
//  m_axis    out  tvalid/tready/tlast    tdata: pixel_x, pixel_y, pixel_color
//
//  one byte per cycle while m_axis does not stall; a pixel passes through the
//  parse/palette read stage, then the output register
//  the palette lives in a single-port-write, registered-read memory, read at most
//  once per byte, so one byte per cycle is the limit
//  asynchronous reset clears all parser state; palette contents stay undefined
//  a stall on m_axis holds the pipeline; s_axis_tready drops once stage 1 also
//  holds a waiting pixel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_pixel_stream_decoder_top
	import bpsd_pkg::*;
#(
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
	parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] file_byte
	input  logic [0:0]             s_axis_tuser,  // [0] first_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [9:0] pixel_x, [19:10] pixel_y,
	                                              // [51:20] pixel_color, [55:52] zero
	output logic                   m_axis_tlast   // last_pixel
);

	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int CW     = $clog2(PALETTE_DEPTH + 1);
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	// parser state
	logic [31:0]           bpos_q, bpos_d;
	logic [31:0]           fshift_q, fshift_d;
	logic [31:0]           doff_q, doff_d;
	logic [32:0]           dend_q, dend_d;
	logic [31:0]           ibytes_q, ibytes_d;
	logic [WW-1:0]         width_q, width_d;
	logic [HW-1:0]         height_q, height_d;
	logic [CW-1:0]         ccount_q, ccount_d;
	logic [WW-1:0]         col_q, col_d;
	logic [HW-1:0]         row_q, row_d;
	logic [1:0]            rphase_q, rphase_d;
	color_phase_t          cphase_q, cphase_d;
	logic [15:0]           cpart_q, cpart_d;
	logic [PAL_BYTE_W-1:0] palb_q, palb_d;

	// per-byte decode
	logic                  accept;
	logic                  first;
	logic [7:0]            fbyte;
	logic [31:0]           p_cur;
	logic [31:0]           fs_cur;
	logic                  emit;
	logic                  lookup;
	logic                  pal_we;
	logic [PAL_AW-1:0]     pal_wa;
	logic [8:0]            pal_idx;
	logic                  pix;
	logic [WW-1:0]         col_inc;
	pixel_t                pix_n;

	// stage 1 and output
	logic                  valid_s1;
	pixel_t                pix_s1;
	logic                  use_pal_s1;
	logic [COLOR_W-1:0]    pal_rd_s1;
	logic                  out_free;
	logic                  adv_s1;
	pixel_t                out_q;

	logic [COLOR_W-1:0]    palette_mem [PALETTE_DEPTH];

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv_s1        = !valid_s1 || out_free;
	assign s_axis_tready = adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign first         = s_axis_tuser[0];
	assign fbyte         = s_axis_tdata;

	assign p_cur   = first ? 32'd0 : bpos_q;
	assign fs_cur  = first ? 32'd0 : fshift_q;
	assign pal_idx = palb_q[PAL_BYTE_W-1:2];
	assign pal_wa  = pal_idx[PAL_AW-1:0];
	assign col_inc = col_q + WW'(1);

	always_comb begin
		bpos_d   = (p_cur == 32'hFFFF_FFFF) ? p_cur : p_cur + 32'd1;
		fshift_d = {fbyte, fs_cur[31:8]};
		doff_d   = doff_q;
		dend_d   = dend_q;
		ibytes_d = ibytes_q;
		width_d  = width_q;
		height_d = height_q;
		ccount_d = ccount_q;
		col_d    = col_q;
		row_d    = row_q;
		rphase_d = rphase_q;
		cphase_d = cphase_q;
		cpart_d  = cpart_q;
		palb_d   = palb_q;
		emit     = 1'b0;
		lookup   = 1'b0;
		pal_we   = 1'b0;
		pix      = 1'b0;
		pix_n    = '0;
		if (first) begin
			doff_d   = '0;
			dend_d   = '0;
			ibytes_d = '0;
			width_d  = '0;
			height_d = '0;
			ccount_d = '0;
			col_d    = '0;
			row_d    = '0;
			rphase_d = '0;
			cphase_d = PH_BLUE;
			cpart_d  = '0;
			palb_d   = '0;
		end
		if (p_cur < 32'(HEADER_BYTES)) begin
			case (p_cur[5:0])
				6'(HDR_DATA_OFFSET): doff_d = fshift_d;
				6'(HDR_WIDTH): begin
					width_d = (fshift_d > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fshift_d[WW-1:0];
				end
				6'(HDR_HEIGHT): begin
					height_d = (fshift_d > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
						: fshift_d[HW-1:0];
				end
				6'(HDR_IMAGE_BYTES): ibytes_d = fshift_d;
				6'(HDR_DATA_END): dend_d = {1'b0, doff_q} + {1'b0, ibytes_q};
				6'(HDR_COLOR_COUNT): begin
					ccount_d = (fshift_d > 32'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
						: fshift_d[CW-1:0];
				end
				default: ;
			endcase
		end else begin
			if (!palb_q[PAL_BYTE_W-1])
				palb_d = palb_q + PAL_BYTE_W'(1);
			if (p_cur < doff_q) begin
				pal_we = (pal_idx < 9'(ccount_q)) && (palb_q[1:0] == 2'd3);
			end else if ({1'b0, p_cur} < dend_q && width_q != '0 && height_q != '0
				&& row_q < height_q) begin
				rphase_d = rphase_q + 2'd1;
				if (col_q >= width_q) begin
					if (rphase_d == 2'd0) begin
						col_d = '0;
						row_d = row_q + HW'(1);
					end
				end else begin
					if (ccount_q != '0) begin
						pix    = 1'b1;
						lookup = ({24'd0, fbyte} < 32'(PALETTE_DEPTH));
					end else begin
						case (cphase_q)
							PH_BLUE: begin
								cpart_d  = {8'd0, fbyte};
								cphase_d = PH_GREEN;
							end
							PH_GREEN: begin
								cpart_d  = {fbyte, cpart_q[7:0]};
								cphase_d = PH_RED;
							end
							default: begin
								pix         = 1'b1;
								pix_n.color = {8'd0, fbyte, cpart_q};
								cphase_d    = PH_BLUE;
							end
						endcase
					end
					if (pix) begin
						emit       = 1'b1;
						pix_n.x    = PIXEL_X_W'(col_q);
						pix_n.y    = PIXEL_Y_W'(height_q - HW'(1) - row_q);
						pix_n.last = (col_inc == width_q) && (row_q == height_q - HW'(1));
						col_d      = col_inc;
						// row ends once the padding lines up on a four byte boundary
						if (col_inc >= width_q && rphase_d == 2'd0) begin
							col_d = '0;
							row_d = row_q + HW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q   <= '0;
			fshift_q <= '0;
			doff_q   <= '0;
			dend_q   <= '0;
			ibytes_q <= '0;
			width_q  <= '0;
			height_q <= '0;
			ccount_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			rphase_q <= '0;
			cphase_q <= PH_BLUE;
			cpart_q  <= '0;
			palb_q   <= '0;
		end else if (accept) begin
			bpos_q   <= bpos_d;
			fshift_q <= fshift_d;
			doff_q   <= doff_d;
			dend_q   <= dend_d;
			ibytes_q <= ibytes_d;
			width_q  <= width_d;
			height_q <= height_d;
			ccount_q <= ccount_d;
			col_q    <= col_d;
			row_q    <= row_d;
			rphase_q <= rphase_d;
			cphase_q <= cphase_d;
			cpart_q  <= cpart_d;
			palb_q   <= palb_d;
		end
	end

	// palette table, registered read
	always_ff @(posedge clk) begin
		if (accept && pal_we)
			palette_mem[pal_wa] <= fshift_d;
		if (accept && lookup)
			pal_rd_s1 <= palette_mem[fbyte[PAL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= accept && emit;
			if (out_free)
				m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_n;
			use_pal_s1 <= lookup;
		end
		if (out_free && valid_s1) begin
			out_q.x     <= pix_s1.x;
			out_q.y     <= pix_s1.y;
			out_q.last  <= pix_s1.last;
			out_q.color <= use_pal_s1 ? pal_rd_s1 : pix_s1.color;
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W - PIXEL_X_W - PIXEL_Y_W - COLOR_W){1'b0}},
		out_q.color, out_q.y, out_q.x};
	assign m_axis_tlast = out_q.last;

	`ASSERT_IMPLIES(a_col_in_row, valid_s1, (11'(pix_s1.x) < 11'(width_q)), "pixel column beyond width")
	`ASSERT_ALWAYS(a_row_bound, (row_q <= height_q), "row count passed image height")
	`ASSERT_IMPLIES(a_s1_from_accept, $rose(valid_s1), $past(s_axis_tvalid && s_axis_tready), "stage 1 loaded without a request")

endmodule
